/* rtl/nod_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nod_pkg
// Shared types and constants of the nearest obstacle distance block: opcodes,
// result limits and the command and status groups that join the controller
// and the datapath.
// ----------------------------------------------------------------------------
package nod_pkg;

	localparam int CFG_W     = 11;
	localparam int IDX_W     = 10;
	localparam int DIST_W    = 16;
	localparam int FRAC_BITS = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

	typedef struct packed {
		logic load_wr;
		logic query_start;
		logic scan_issue;
		logic root_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic issue_done;
		logic pipe_busy;
		logic root_done;
		logic root_busy;
	} status_t;

endpackage
`default_nettype wire

/* rtl/nearest_obstacle_distance.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_obstacle_distance
// Brute-force nearest obstacle search returning the distance in unsigned
// 8.8 fixed point, saturated at 65535.
//
// A request is taken at a rising edge with start high and busy low. With op
// low it writes {pos_x, pos_y} to map entry entry_index at that edge and
// gives no result; busy stays low. With op high it searches the first
// num_obstacles entries for the point nearest to (pos_x, pos_y).
// The user writes num_obstacles through cfg_wr_en and cfg_wr_data only while
// idle (not enforced by the block); it is clamped to MAP_DEPTH.
// During a query the map memory delivers two entries per cycle through a
// three-stage distance pipeline, then the square root unit resolves one
// result bit per cycle. The result appears on distance with done high for
// exactly one cycle, the first cycle in which busy is low again, so the
// next request can be taken at the edge that ends it; the receiver cannot
// stall. An empty search returns 65535. Reset clears the controller and
// the num_obstacles register; the map holds no defined contents until
// entries are loaded.
// ----------------------------------------------------------------------------
module nearest_obstacle_distance #(
	parameter int MAP_DEPTH  = 1024,
	parameter int COORD_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [nod_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      op,
	input  wire logic [nod_pkg::IDX_W-1:0] entry_index,
	input  wire logic [COORD_BITS-1:0]     pos_x,
	input  wire logic [COORD_BITS-1:0]     pos_y,
	output logic                           done,
	output logic [nod_pkg::DIST_W-1:0]     distance
);

	import nod_pkg::*;

	cmd_t    cmd;
	status_t status;

	nod_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	nod_datapath #(
		.MAP_DEPTH (MAP_DEPTH),
		.COORD_BITS(COORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.status     (status),
		.entry_index(entry_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.done       (done),
		.distance   (distance)
	);

endmodule
`default_nettype wire

/* rtl/nod_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nod_sqrt
// Iterative restoring square root, one result bit per cycle. A start pulse
// loads the radicand; done pulses when the floor of the root is ready.
// ----------------------------------------------------------------------------
module nod_sqrt #(
	parameter int RAD_W = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  busy,
	output logic                  done,
	output logic [RAD_W/2-1:0]    root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [ROOT_W+2:0] acc;
	logic [ROOT_W+2:0] trial;
	logic              fits;

	always_comb begin
		acc   = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		fits  = (acc >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= (ROOT_W+1)'(acc - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= acc[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign root = root_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("square root restarted while running");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cnt_q) == CNT_W'(1))
		else $error("square root done without a final step");

endmodule
`default_nettype wire

/* rtl/nod_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nod_datapath
// Obstacle map memory, two-lane distance pipeline, running minimum, square
// root unit and the result register.
// ----------------------------------------------------------------------------
module nod_datapath #(
	parameter int MAP_DEPTH  = 1024,
	parameter int COORD_BITS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [nod_pkg::CFG_W-1:0]  cfg_wr_data,
	input  wire nod_pkg::cmd_t              cmd,
	output nod_pkg::status_t                status,
	input  wire logic [nod_pkg::IDX_W-1:0]  entry_index,
	input  wire logic [COORD_BITS-1:0]      pos_x,
	input  wire logic [COORD_BITS-1:0]      pos_y,
	output logic                            done,
	output logic [nod_pkg::DIST_W-1:0]      distance
);

	import nod_pkg::*;

	localparam int C      = COORD_BITS;
	localparam int E_W    = 2 * C;
	localparam int D_W    = 2 * C + 1;
	localparam int AW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int ACW    = $clog2(MAP_DEPTH + 2);
	localparam int RAD_W  = D_W + FRAC_BITS + 1;
	localparam int ROOT_W = RAD_W / 2;

	logic [E_W-1:0] mem_q [MAP_DEPTH];

	logic [CFG_W-1:0] num_obstacles_q;
	logic [ACW-1:0]   count_q;
	logic [ACW-1:0]   addr_q;
	logic [C-1:0]     px_q;
	logic [C-1:0]     py_q;
	logic [D_W-1:0]   best_q;
	logic             found_q;

	logic             issue;
	logic             issue_done;
	logic [ACW-1:0]   addr1;
	logic             lane1_ok;
	logic [AW-1:0]    ra0;
	logic [AW-1:0]    ra1;

	logic [E_W-1:0]   rd_s1 [2];
	logic [1:0]       v_s1;
	logic [D_W-1:0]   d_s2 [2];
	logic [1:0]       v_s2;
	logic [D_W-1:0]   m_s3;
	logic             v_s3;

	logic [D_W-1:0]   d_next [2];

	logic              root_busy;
	logic              root_done;
	logic [ROOT_W-1:0] root;
	logic [DIST_W-1:0] root_sat;
	logic              done_q;
	logic [DIST_W-1:0] distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_obstacles_q <= '0;
		end else if (cfg_wr_en) begin
			num_obstacles_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (32'(entry_index) < MAP_DEPTH)) begin
			mem_q[AW'(entry_index)] <= {pos_x, pos_y};
		end
	end

	always_comb begin
		issue_done = (addr_q >= count_q);
		issue      = cmd.scan_issue && !issue_done;
		addr1      = addr_q + ACW'(1);
		lane1_ok   = (addr1 < count_q);
		ra0        = issue ? addr_q[AW-1:0] : '0;
		ra1        = (issue && lane1_ok) ? addr1[AW-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		rd_s1[0] <= mem_q[ra0];
		rd_s1[1] <= mem_q[ra1];
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			addr_q <= '0;
			if (32'(num_obstacles_q) > MAP_DEPTH) begin
				count_q <= ACW'(MAP_DEPTH);
			end else begin
				count_q <= ACW'(num_obstacles_q);
			end
		end else if (issue) begin
			addr_q <= addr_q + ACW'(2);
		end
	end

	always_comb begin
		logic [C-1:0] ox;
		logic [C-1:0] oy;
		logic [C-1:0] dx;
		logic [C-1:0] dy;
		for (int i = 0; i < 2; i++) begin
			ox = rd_s1[i][E_W-1:C];
			oy = rd_s1[i][C-1:0];
			dx = (px_q >= ox) ? (px_q - ox) : (ox - px_q);
			dy = (py_q >= oy) ? (py_q - oy) : (oy - py_q);
			d_next[i] = D_W'(dx * dx) + D_W'(dy * dy);
		end
	end

	always_ff @(posedge clk) begin
		d_s2[0] <= d_next[0];
		d_s2[1] <= d_next[1];
		m_s3    <= (v_s2[1] && (d_s2[1] < d_s2[0])) ? d_s2[1] : d_s2[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= '0;
			v_s2    <= '0;
			v_s3    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= {issue && lane1_ok, issue};
			v_s2 <= v_s1;
			v_s3 <= v_s2[0];
			if (cmd.query_start) begin
				found_q <= 1'b0;
			end else if (v_s3) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && (!found_q || (m_s3 < best_q))) begin
			best_q <= m_s3;
		end
	end

	nod_sqrt #(
		.RAD_W(RAD_W)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.radicand({1'b0, best_q, FRAC_BITS'(0)}),
		.busy    (root_busy),
		.done    (root_done),
		.root    (root)
	);

	always_comb begin
		if (32'(root) > 32'(DIST_MAX)) begin
			root_sat = DIST_MAX;
		end else begin
			root_sat = DIST_W'(root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			distance_q <= found_q ? root_sat : DIST_MAX;
		end
	end

	always_comb begin
		status.issue_done = issue_done;
		status.pipe_busy  = (v_s1 != '0) || (v_s2 != '0) || v_s3;
		status.root_done  = root_done;
		status.root_busy  = root_busy;
	end

	assign done     = done_q;
	assign distance = distance_q;

	a_lane_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1[1] |-> v_s1[0])
		else $error("second lane valid without the first");

	a_no_scan_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_busy |-> !status.pipe_busy)
		else $error("distance pipeline active during square root");

endmodule
`default_nettype wire

/* rtl/nod_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nod_ctrl
// Controller state machine: takes requests, sequences the map scan, the
// pipeline drain, the square root and the result.
// ----------------------------------------------------------------------------
module nod_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             op,
	input  wire nod_pkg::status_t status,
	output nod_pkg::cmd_t         cmd,
	output logic                  busy
);

	import nod_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ROOT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_QUERY) begin
						cmd.query_start = 1'b1;
						state_d         = ST_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.issue_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.root_start = 1'b1;
					state_d        = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (status.root_done) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_root_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		status.root_done |-> state_q == ST_ROOT)
		else $error("square root finished outside its state");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit && state_q == ST_IDLE)
		else $error("result issued twice for one query");

endmodule
`default_nettype wire

/* bench/nearest_obstacle_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_obstacle_distance_tb
// Self-checking bench for the nearest obstacle distance block. A driver feeds
// load and query requests from a queue with random gaps. A monitor compares
// every distance strobe with the value that the bench's own map and search
// predict. The search count is rewritten between phases, only while the
// block is idle. The map is filled mostly in order, so that each query
// scans written entries only. A watchdog ends a run that stops making
// progress.
// ----------------------------------------------------------------------------
module nearest_obstacle_distance_tb;

	import nod_pkg::*;

	localparam int MAP_DEPTH   = 1024;
	localparam int COORD_BITS  = 8;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic                  op;
		logic [IDX_W-1:0]      entry_index;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} request_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  start       = 1'b0;
	logic                  op          = 1'b0;
	logic [IDX_W-1:0]      entry_index = '0;
	logic [COORD_BITS-1:0] pos_x       = '0;
	logic [COORD_BITS-1:0] pos_y       = '0;
	logic                  busy;
	logic                  done;
	logic [DIST_W-1:0]     distance;

	request_t              pending_requests[$];
	logic [DIST_W-1:0]     expected_distances[$];
	logic [2*COORD_BITS-1:0] obstacle_copy [MAP_DEPTH];
	bit                    entry_loaded [MAP_DEPTH];
	int                    search_count = 0;
	int                    map_fill = 0;
	int                    idle_max = 16;
	int                    errors = 0;
	int                    request_count = 0;
	int                    result_count = 0;
	int                    seen_requests = 0;
	int                    seen_results = 0;
	int                    stall_cycles = 0;
	int                    gap_left = 0;
	logic [DIST_W-1:0]     wanted;

	nearest_obstacle_distance #(
		.MAP_DEPTH (MAP_DEPTH),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.entry_index(entry_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.done       (done),
		.distance   (distance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DIST_W-1:0] nearest_distance(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		int          count;
		int          dx;
		int          dy;
		int          d;
		int          best;
		logic [63:0] scaled;
		logic [63:0] root;
		logic [63:0] trial;
		count = (search_count > MAP_DEPTH) ? MAP_DEPTH : search_count;
		if (count == 0)
			return DIST_MAX;
		best = 0;
		for (int k = 0; k < count; k++) begin
			dx = int'(px) - int'(obstacle_copy[k][2*COORD_BITS-1:COORD_BITS]);
			dy = int'(py) - int'(obstacle_copy[k][COORD_BITS-1:0]);
			d = dx * dx + dy * dy;
			if (k == 0 || d < best)
				best = d;
		end
		scaled = 64'(best) << FRAC_BITS;
		root = '0;
		for (int b = 20; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= scaled)
				root = trial;
		end
		if (root > 64'(DIST_MAX))
			return DIST_MAX;
		return root[DIST_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t next_request;
		int       wait_draw;
		if (!arst_n) begin
			start <= 1'b0;
			op <= OP_LOAD;
			entry_index <= '0;
			pos_x <= '0;
			pos_y <= '0;
		end else begin
			if (start && !busy) begin
				if (op == OP_LOAD)
					obstacle_copy[entry_index] = {pos_x, pos_y};
				else
					expected_distances.push_back(nearest_distance(pos_x, pos_y));
				request_count <= request_count + 1;
				wait_draw = $urandom_range(0, idle_max);
				if (pending_requests.size() != 0 && wait_draw == 0) begin
					next_request = pending_requests.pop_front();
					op <= next_request.op;
					entry_index <= next_request.entry_index;
					pos_x <= next_request.pos_x;
					pos_y <= next_request.pos_y;
				end else begin
					start <= 1'b0;
					gap_left <= (wait_draw > 0) ? wait_draw - 1 : 0;
				end
			end else if (!start && pending_requests.size() != 0) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else begin
					next_request = pending_requests.pop_front();
					op <= next_request.op;
					entry_index <= next_request.entry_index;
					pos_x <= next_request.pos_x;
					pos_y <= next_request.pos_y;
					start <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_distances.size() == 0) begin
				$display("%0t unexpected distance: expected none, actual %0d", $time, distance);
				errors = errors + 1;
			end else begin
				wanted = expected_distances.pop_front();
				if (distance !== wanted) begin
					$display("%0t distance mismatch: expected %0d, actual %0d",
						$time, wanted, distance);
					errors = errors + 1;
				end
			end
			result_count <= result_count + 1;
		end
	end

	always @(posedge clk) begin
		if (request_count != seen_requests || result_count != seen_results) begin
			seen_requests <= request_count;
			seen_results <= result_count;
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_request(input logic req_op, input logic [IDX_W-1:0] idx,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		request_t req;
		req.op = req_op;
		req.entry_index = idx;
		req.pos_x = x;
		req.pos_y = y;
		pending_requests.push_back(req);
		if (req_op == OP_LOAD) begin
			entry_loaded[idx] = 1'b1;
			while (map_fill < MAP_DEPTH && entry_loaded[map_fill])
				map_fill++;
		end
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || start || expected_distances.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_search_count(input int value);
		wait_idle();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		search_count = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int random_items;
		int full_queries;
		int full_phases;
		int count;
		int phase_len;
		bit full;
		logic [IDX_W-1:0] idx;
		random_items = 0;
		full_queries = 0;
		full_phases = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The search count is still at its reset value of zero here.
		push_request(OP_QUERY, 10'h3FF, 8'd12, 8'd34);
		push_request(OP_LOAD, 10'd0, 8'd0, 8'd0);
		push_request(OP_LOAD, 10'h3FF, 8'hFF, 8'hFF);
		push_request(OP_QUERY, 10'd0, 8'hFF, 8'hFF);

		write_search_count(1);
		push_request(OP_QUERY, 10'd0, 8'hFF, 8'hFF);
		push_request(OP_QUERY, 10'd5, 8'd0, 8'd0);
		push_request(OP_QUERY, 10'd0, 8'd0, 8'd1);
		push_request(OP_QUERY, 10'd0, 8'd3, 8'd4);
		push_request(OP_QUERY, 10'd0, 8'hFF, 8'd0);
		push_request(OP_LOAD, 10'd1, 8'hFF, 8'hFF);
		push_request(OP_LOAD, 10'd2, 8'd128, 8'd7);

		write_search_count(3);
		push_request(OP_QUERY, 10'd0, 8'hFF, 8'hFF);
		push_request(OP_QUERY, 10'd0, 8'd200, 8'd100);
		push_request(OP_QUERY, 10'd0, 8'd0, 8'hFF);

		write_search_count(0);
		push_request(OP_QUERY, 10'd0, 8'd1, 8'd1);

		while (!(random_items >= 1145 && map_fill == MAP_DEPTH && full_queries >= 48)) begin
			if (map_fill == MAP_DEPTH) begin
				case (full_phases)
					0: count = 2047;
					1: count = MAP_DEPTH;
					default: begin
						case ($urandom_range(0, 3))
							0: count = 2047;
							1: count = MAP_DEPTH;
							2: count = $urandom_range(MAP_DEPTH + 1, 2047);
							default: count = $urandom_range(0, MAP_DEPTH);
						endcase
					end
				endcase
				full_phases++;
			end else begin
				case ($urandom_range(0, 7))
					0: count = 0;
					1, 2: count = map_fill;
					3, 4, 5: count = $urandom_range(0, (map_fill < 8) ? map_fill : 8);
					default: count = $urandom_range(0, map_fill);
				endcase
			end
			write_search_count(count);
			idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) begin
				full = (map_fill == MAP_DEPTH);
				if (full ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) != 0)) begin
					if (!full && $urandom_range(0, 15) != 0)
						idx = IDX_W'(map_fill);
					else
						idx = IDX_W'($urandom_range(0, MAP_DEPTH - 1));
					push_request(OP_LOAD, idx, COORD_BITS'($urandom_range(0, 255)),
						COORD_BITS'($urandom_range(0, 255)));
				end else begin
					push_request(OP_QUERY, IDX_W'($urandom_range(0, MAP_DEPTH - 1)),
						COORD_BITS'($urandom_range(0, 255)),
						COORD_BITS'($urandom_range(0, 255)));
					if (full)
						full_queries++;
				end
				random_items++;
			end
		end

		wait_idle();
		repeat (600) @(posedge clk);
		if (expected_distances.size() != 0)
			$display("%0t missing results: %0d distances never arrived",
				$time, expected_distances.size());
		if (errors == 0 && expected_distances.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
